// ----- src/sorted_array_engine_assert.svh -----
// Assertion macros used by the checker of the sorted array engine.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef SORTED_ARRAY_ENGINE_ASSERT_SVH
`define SORTED_ARRAY_ENGINE_ASSERT_SVH

// property that must hold at every edge outside reset
`define SAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// when cond holds, res must hold in the next cycle
`define SAE_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) else $error(msg);

`endif

// ----- src/sae_pkg.sv -----
// Types and constants for the sorted array engine.
// No dependencies; imported by the top level and by its checker.
package sae_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int IDX_W  = 6;
  localparam int CAP_W  = 7;
  localparam int FILL_W = 7;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_READ   = 3'd3,
    OP_CHECK  = 3'd4,
    OP_PART   = 3'd5
  } op_t;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic [FILL_W-1:0]        fill_count;
    logic                     in_order;
    logic [STAT_W-1:0]        status;
  } out_beat_t;

endpackage

// ----- src/sorted_array_engine.sv -----
// Sorted array engine: table of signed entries held in one synchronous RAM.
// Depends on sae_pkg.
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  in_data (in_beat_t)
//   out      out  out_valid / out_stall out_data (out_beat_t)
//   cfg      in   cfg_valid / cfg_ready cfg_data (capacity)
//
// One command at a time; the walks go through the single RAM read port.
// Clear, check, refused ops and out-of-range reads go straight to S_FIN. Insert
// moves larger entries up one place at a time. Partition swaps, then walks the
// table to recompute the order flag; it is skipped below two entries.
// rst is synchronous: count 0, in order, capacity 64; the RAM is not cleared.
// A finished beat waits in the output register while out_stall is high.
module sorted_array_engine
  import sae_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int PTR_W = CNT_W + 1;
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [3:0] {
    S_IDLE, S_APP, S_INS, S_INS_PUT, S_RD,
    S_P_LO, S_P_HI, S_P_SW, S_ORD, S_FIN
  } state_t;

  state_t state;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_q;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_wa;
  logic [ADDR_W-1:0]        mem_ra;
  logic signed [DATA_W-1:0] mem_wd;

  logic [CAP_W-1:0]         capacity;
  logic [CNT_W-1:0]         count;
  logic                     sorted;
  logic signed [DATA_W-1:0] cur_value;
  logic signed [DATA_W-1:0] res_data;
  logic [STAT_W-1:0]        res_status;
  logic [CNT_W-1:0]         pos;
  logic signed [PTR_W-1:0]  lo;
  logic signed [PTR_W-1:0]  hi;
  logic signed [DATA_W-1:0] lo_val;
  logic [CNT_W-1:0]         k;
  logic                     ok;
  logic signed [DATA_W-1:0] prev;

  logic                     in_acc;
  logic                     full;
  logic                     idx_bad;
  logic signed [PTR_W-1:0]  cnt_s;
  logic                     lo_adv;
  logic                     hi_adv;
  logic                     ok_next;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign full = (LIM_W'(count) >= LIM_W'(capacity)) || (LIM_W'(count) >= LIM_W'(DEPTH));
  assign idx_bad = LIM_W'(in_data.index) >= LIM_W'(count);
  assign cnt_s   = signed'({1'b0, count});
  assign lo_adv  = (lo < cnt_s) && (rd_q < 0);
  assign hi_adv  = (hi >= 0) && (rd_q >= 0);
  assign ok_next = ok && !((k != '0) && (prev > rd_q));

  // RAM port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_q;
    mem_ra = '0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.opcode)
            OP_APPEND, OP_INSERT: begin
              if (!full) begin
                if (count == '0) begin
                  mem_we = 1'b1;
                  mem_wd = in_data.value;
                end else begin
                  mem_ra = ADDR_W'(count - CNT_W'(1));
                end
              end
            end
            OP_READ: mem_ra = ADDR_W'(in_data.index);
            default: mem_ra = '0;
          endcase
        end
      end
      S_APP: begin
        mem_we = 1'b1;
        mem_wa = ADDR_W'(count);
        mem_wd = cur_value;
      end
      S_INS: begin
        mem_we = 1'b1;
        mem_wa = ADDR_W'(pos);
        if (rd_q > cur_value) begin
          mem_wd = rd_q;
          mem_ra = ADDR_W'(pos - CNT_W'(2));
        end else begin
          mem_wd = cur_value;
        end
      end
      S_INS_PUT: begin
        mem_we = 1'b1;
        mem_wa = ADDR_W'(pos);
        mem_wd = cur_value;
      end
      S_P_LO: mem_ra = lo_adv ? ADDR_W'(lo + PTR_W'(1)) : ADDR_W'(hi);
      S_P_HI: begin
        if (hi_adv) begin
          mem_ra = ADDR_W'(hi - PTR_W'(1));
        end else if (lo < hi) begin
          mem_we = 1'b1;
          mem_wa = ADDR_W'(lo);
          mem_wd = rd_q;
        end
      end
      S_P_SW: begin
        mem_we = 1'b1;
        mem_wa = ADDR_W'(hi);
        mem_wd = lo_val;
        mem_ra = ADDR_W'(lo);
      end
      S_ORD: mem_ra = ADDR_W'(k + CNT_W'(1));
      default: mem_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sorted    <= 1'b1;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            cur_value <= in_data.value;
            res_data  <= '0;
            case (in_data.opcode)
              OP_CLEAR: begin
                count      <= '0;
                sorted     <= 1'b1;
                res_status <= STAT_OK;
                state      <= S_FIN;
              end
              OP_APPEND, OP_INSERT: begin
                if (full) begin
                  res_status <= STAT_FULL;
                  state      <= S_FIN;
                end else if (count == '0) begin
                  count      <= CNT_W'(1);
                  res_status <= STAT_OK;
                  state      <= S_FIN;
                end else begin
                  pos        <= count;
                  res_status <= STAT_OK;
                  state      <= (in_data.opcode == OP_APPEND) ? S_APP : S_INS;
                end
              end
              OP_READ: begin
                if (idx_bad) begin
                  res_status <= STAT_RANGE;
                  state      <= S_FIN;
                end else begin
                  res_status <= STAT_OK;
                  state      <= S_RD;
                end
              end
              OP_PART: begin
                res_status <= STAT_OK;
                if (count >= CNT_W'(2)) begin
                  lo    <= '0;
                  hi    <= cnt_s - PTR_W'(1);
                  state <= S_P_LO;
                end else begin
                  state <= S_FIN;
                end
              end
              default: begin
                res_status <= STAT_OK;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_APP: begin
          // appended value below the old top entry breaks the order
          if (rd_q > cur_value) begin
            sorted <= 1'b0;
          end
          count <= count + CNT_W'(1);
          state <= S_FIN;
        end
        S_INS: begin
          // insertion keeps the order flag as it was
          if (rd_q > cur_value) begin
            pos <= pos - CNT_W'(1);
            if (pos == CNT_W'(1)) begin
              state <= S_INS_PUT;
            end
          end else begin
            count <= count + CNT_W'(1);
            state <= S_FIN;
          end
        end
        S_INS_PUT: begin
          count <= count + CNT_W'(1);
          state <= S_FIN;
        end
        S_RD: begin
          res_data <= rd_q;
          state    <= S_FIN;
        end
        S_P_LO: begin
          if (lo_adv) begin
            lo <= lo + PTR_W'(1);
          end else begin
            lo_val <= rd_q;
            state  <= S_P_HI;
          end
        end
        S_P_HI: begin
          if (hi_adv) begin
            hi <= hi - PTR_W'(1);
          end else if (lo < hi) begin
            state <= S_P_SW;
          end else begin
            k     <= '0;
            ok    <= 1'b1;
            state <= S_ORD;
          end
        end
        S_P_SW: state <= S_P_LO;
        S_ORD: begin
          prev <= rd_q;
          ok   <= ok_next;
          if (k == count - CNT_W'(1)) begin
            sorted <= ok_next;
            state  <= S_FIN;
          end else begin
            k <= k + CNT_W'(1);
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_data.read_data  <= res_data;
            out_data.fill_count <= FILL_W'(count);
            out_data.in_order   <= sorted;
            out_data.status     <= res_status;
            out_valid           <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/sae_checker.sv -----
// Port-level checks for the sorted array engine, bound to the top level.
// Depends on sae_pkg and sorted_array_engine_assert.svh.
`include "sorted_array_engine_assert.svh"

module sae_checker
  import sae_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  logic held;
  logic took;
  logic err_beat;
  logic short_beat;

  assign held       = out_valid && out_stall;
  assign took       = in_valid && !in_stall;
  assign err_beat   = out_valid && (out_data.status != STAT_OK);
  assign short_beat = out_valid && (out_data.fill_count < FILL_W'(2));

  `SAE_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(out_data), "stalled beat changed")
  `SAE_ASSERT(a_fill_bound, !out_valid || (out_data.fill_count <= DEPTH), "fill past depth")
  `SAE_ASSERT(a_err_data, !err_beat || (out_data.read_data == '0), "error beat with data")
  `SAE_ASSERT(a_short_order, !short_beat || out_data.in_order, "short table out of order")
  `SAE_ASSERT_NEXT(a_take_busy, took, in_stall, "input not stalled after a beat")

endmodule

bind sorted_array_engine sae_checker u_sae_checker (.*);

// ----- tb/sorted_array_engine_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sorted_array_engine: directed command table, then random
// command streams under varied back-pressure; results checked vs shadow or typed-in rows.
// Depends on sae_pkg and the sorted_array_engine RTL.
module sorted_array_engine_tb;
  import sae_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_beat_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_beat_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  // sideband travelling with each command beat: typed-in expectation for directed rows
  bit        cmd_typed = 1'b0;
  out_beat_t cmd_want = '0;

  // shadow copy of the engine state
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int shadow_count = 0;
  int shadow_cap = int'(CAP_RESET);

  out_beat_t pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_granted = 0;
  int hold_left = 0;
  int cycle_count = 0;

  int cmds_accepted = 0;
  int results_checked = 0;
  int full_refusals = 0;
  int range_errors = 0;
  int cap_writes = 0;
  int mismatches = 0;

  typedef struct {
    bit               is_cfg;
    logic [CAP_W-1:0] cap;
    in_beat_t         cmd;
    bit               typed;
    out_beat_t        want;
  } plan_row_t;

  plan_row_t directed_plan [$];

  sorted_array_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Apply one command to the shadow table and return the result it should give.
  function automatic out_beat_t apply_cmd(in_beat_t c);
    out_beat_t r;
    int lim, pos, lo, hi;
    logic signed [DATA_W-1:0] v, t;
    r = '0;
    v = c.value;
    lim = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
    case (c.opcode)
      OP_CLEAR: begin
        shadow_count = 0;
      end
      OP_APPEND, OP_INSERT: begin
        if (shadow_count >= lim) begin
          r.status = STAT_FULL;
        end else if (c.opcode == OP_APPEND) begin
          shadow_entries[shadow_count] = v;
          shadow_count++;
        end else begin
          // walk down from the top, moving larger entries up one place
          pos = shadow_count;
          while (pos > 0 && shadow_entries[pos-1] > v) begin
            shadow_entries[pos] = shadow_entries[pos-1];
            pos--;
          end
          shadow_entries[pos] = v;
          shadow_count++;
        end
      end
      OP_READ: begin
        if (c.index >= shadow_count) r.status = STAT_RANGE;
        else r.read_data = shadow_entries[c.index];
      end
      OP_PART: begin
        lo = 0;
        hi = shadow_count - 1;
        while (lo < hi) begin
          while (lo < shadow_count && shadow_entries[lo] < 0) lo++;
          while (hi >= 0 && shadow_entries[hi] >= 0) hi--;
          if (lo < hi) begin
            t = shadow_entries[lo];
            shadow_entries[lo] = shadow_entries[hi];
            shadow_entries[hi] = t;
          end
        end
      end
      default: begin
      end
    endcase
    r.fill_count = FILL_W'(shadow_count);
    r.in_order = 1'b1;
    for (int k = 1; k < shadow_count; k++)
      if (shadow_entries[k-1] > shadow_entries[k]) r.in_order = 1'b0;
    return r;
  endfunction

  // Beat tracking: commands and capacity writes are applied as they are taken,
  // results are compared against the oldest outstanding expectation.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        shadow_cap = int'(cfg_data);
        cap_writes++;
      end
      if (in_valid && !in_stall) begin
        want = apply_cmd(in_data);
        if (cmd_typed) want = cmd_want;
        pending_results.push_back(want);
        cmds_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (want.status == STAT_FULL) full_refusals++;
          if (want.status == STAT_RANGE) range_errors++;
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", want.read_data, out_data.read_data);
            mismatches++;
          end
          if (out_data.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, out_data.fill_count);
            mismatches++;
          end
          if (out_data.in_order !== want.in_order) begin
            $error("in_order: expected %0d, got %0d", want.in_order, out_data.in_order);
            mismatches++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatches++;
          end
        end
      end
    end
  end

  // Result side: random stall, or a long hold-off counted here when one is asked for.
  always @(negedge clk) begin
    if (hold_left == 0 && hold_granted != hold_requests) begin
      hold_granted++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Entered and left at a falling edge; valid stays high after the beat until the
  // next command or an explicit idle lowers it.
  task automatic send_cmd(input in_beat_t cmd, input bit typed = 1'b0,
                          input out_beat_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= cmd;
    cmd_typed <= typed;
    cmd_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_capacity(input int cap);
    wait_drained();
    write_capacity(CAP_W'(cap));
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      4, 5: return DATA_W'($urandom_range(16)) - 32'd8;  // small, so duplicates occur
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t random_cmd();
    in_beat_t c;
    int pick;
    pick = $urandom_range(99);
    c.value = rand_value();
    c.index = IDX_W'($urandom_range(63));
    if (pick < 3) begin
      c.opcode = OP_CLEAR;
    end else if (pick < 35) begin
      c.opcode = OP_INSERT;
    end else if (pick < 50) begin
      c.opcode = OP_APPEND;
    end else if (pick < 75) begin
      c.opcode = OP_READ;
      if (shadow_count > 0 && pick < 70) c.index = IDX_W'($urandom_range(shadow_count - 1));
    end else if (pick < 83) begin
      c.opcode = OP_CHECK;
    end else if (pick < 93) begin
      c.opcode = OP_PART;
    end else begin
      c.opcode = ($urandom_range(1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
    end
    return c;
  endfunction

  task automatic random_run(input int n);
    repeat (n) send_cmd(random_cmd());
  endtask

  // clear, then add DEPTH + 2 entries, two more than the table can hold
  task automatic fill_table();
    in_beat_t c;
    c = '0;
    c.opcode = OP_CLEAR;
    send_cmd(c);
    repeat (DEPTH + 2) begin
      c.opcode = ($urandom_range(2) == 0) ? OP_APPEND : OP_INSERT;
      c.value = rand_value();
      send_cmd(c);
    end
  endtask

  function automatic void plan(input bit typed, input logic [OP_W-1:0] op,
                               input logic [DATA_W-1:0] val, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] rd = '0, input int fill = 0,
                               input bit ord = 1'b1, input logic [STAT_W-1:0] st = STAT_OK);
    plan_row_t row;
    row = '{default: '0};
    row.cmd.opcode = op;
    row.cmd.value = val;
    row.cmd.index = idx;
    row.typed = typed;
    row.want.read_data = rd;
    row.want.fill_count = FILL_W'(fill);
    row.want.in_order = ord;
    row.want.status = st;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_cap(input int cap);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cap = CAP_W'(cap);
    directed_plan.push_back(row);
  endfunction

  initial begin
    // empty table, signed extremes, partition and reads
    plan(1, OP_READ,   '0, 0, '0, 0, 1, STAT_RANGE);
    plan(1, OP_CHECK,  '0, 0, '0, 0, 1, STAT_OK);
    plan(1, OP_PART,   '0, 0, '0, 0, 1, STAT_OK);
    plan(1, OP_APPEND, 32'h7FFF_FFFF, 0, '0, 1, 1, STAT_OK);
    plan(1, OP_APPEND, 32'h8000_0000, 0, '0, 2, 0, STAT_OK);
    plan(1, OP_READ,   '0, 1, 32'h8000_0000, 2, 0, STAT_OK);
    plan(1, OP_READ,   '0, 63, '0, 2, 0, STAT_RANGE);
    plan(0, OP_PART,   '0, 0);
    plan(0, OP_INSERT, '0, 0);
    plan(0, OP_INSERT, '1, 0);
    plan(0, OP_INSERT, 32'h8000_0000, 0);
    plan(0, OP_UNUSED_6, '1, 63);
    plan(0, OP_UNUSED_7, 32'h5A5A_A5A5, 21);
    // insert into a table left unsorted by an append
    plan(0, OP_APPEND, -32'sd5, 0);
    plan(0, OP_INSERT, 32'd3, 42);
    plan(0, OP_CHECK,  '0, 0);
    plan(0, OP_PART,   '0, 0);
    plan(0, OP_READ,   '0, 2);
    plan(1, OP_CLEAR,  '1, 63, '0, 0, 1, STAT_OK);
    // zero capacity refuses every append and insert
    plan_cap(0);
    plan(1, OP_APPEND, 32'd1, 0, '0, 0, 1, STAT_FULL);
    plan(1, OP_INSERT, 32'd1, 0, '0, 0, 1, STAT_FULL);
    plan_cap(2);
    plan(1, OP_INSERT, 32'd9, 0, '0, 1, 1, STAT_OK);
    plan(1, OP_APPEND, 32'd4, 0, '0, 2, 0, STAT_OK);
    // capacity dropped below the fill count: entries stay, adds refused
    plan_cap(1);
    plan(1, OP_INSERT, 32'd5, 0, '0, 2, 0, STAT_FULL);
    plan(1, OP_READ,   '0, 0, 32'd9, 2, 0, STAT_OK);
    plan_cap(64);

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) set_capacity(directed_plan[i].cap);
      else send_cmd(directed_plan[i].cmd, directed_plan[i].typed, directed_plan[i].want);
    end

    // sender mostly busy, receiver mostly stalling
    send_idle_pct = 16;
    recv_idle_pct = 81;
    set_capacity(127);
    fill_table();
    random_run(30);
    hold_requests++;
    random_run(30);
    wait_drained();
    random_run(20);
    set_capacity($urandom_range(2, 63));
    fill_table();

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 81;
    recv_idle_pct = 16;
    set_capacity(1);
    random_run(30);
    set_capacity(64);
    fill_table();
    random_run(45);
    wait_drained();
    random_run(45);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_capacity(0);
    random_run(20);
    set_capacity($urandom_range(0, 127));
    random_run(80);
    set_capacity(64);
    random_run(40);
    hold_requests++;
    random_run(80);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d commands across %0d capacity writes; %0d results checked,",
             cmds_accepted, cap_writes, results_checked);
    $display("of which %0d refused as full and %0d reads out of range.",
             full_refusals, range_errors);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
